// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, skipped while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/aaf_pkg.sv =====
// package: opcodes, condition codes and beat types of the accumulator alu
package aaf_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_ADC = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_SBB = 4'd3;
    localparam logic [3:0] OP_CMP = 4'd4;
    localparam logic [3:0] OP_AND = 4'd5;
    localparam logic [3:0] OP_XOR = 4'd6;
    localparam logic [3:0] OP_INR = 4'd7;
    localparam logic [3:0] OP_DCR = 4'd8;
    localparam logic [3:0] OP_STC = 4'd9;

    localparam logic [3:0] CC_ALWAYS = 4'd0;
    localparam logic [3:0] CC_NZ     = 4'd1;
    localparam logic [3:0] CC_Z      = 4'd2;
    localparam logic [3:0] CC_C      = 4'd3;
    localparam logic [3:0] CC_NC     = 4'd4;
    localparam logic [3:0] CC_P      = 4'd5;
    localparam logic [3:0] CC_M      = 4'd6;
    localparam logic [3:0] CC_PE     = 4'd7;
    localparam logic [3:0] CC_PO     = 4'd8;

    localparam logic [15:0] PC_STEP_ALU  = 16'd1;
    localparam logic [15:0] PC_STEP_JUMP = 16'd3;

    typedef struct packed {
        logic [3:0]  op;
        logic        is_jump;
        logic [7:0]  operand;
        logic [3:0]  cond;
        logic [15:0] pc;
        logic [15:0] jump_target;
    } t_item;

    typedef struct packed {
        logic [7:0] acc;
        logic       cy;
        logic       z;
        logic       s;
        logic       p;
        logic       ac;
    } t_state;

    typedef struct packed {
        logic [7:0]  acc_out;
        logic [7:0]  reg_out;
        logic        cy_out;
        logic        z_out;
        logic        s_out;
        logic        p_out;
        logic        ac_out;
        logic [15:0] next_pc;
        logic        branch_taken;
    } t_result;

    function automatic logic even_parity(input logic [7:0] v);
        return ~^v;
    endfunction

endpackage

// ===== src/aaf_exec.sv =====
// combinational execute step: alu operation or jump decision
module aaf_exec (
    input  aaf_pkg::t_item   i_item,
    input  aaf_pkg::t_state  i_state,
    output aaf_pkg::t_state  o_state,
    output aaf_pkg::t_result o_result
);
    import aaf_pkg::*;

    logic [8:0] sum;
    logic [8:0] diff;
    logic [7:0] logic_val;
    logic [7:0] reg_val;
    logic       reg_used;
    logic       taken;
    t_state     st;

    always_comb begin
        taken = 1'b0;
        unique case (i_item.cond)
            CC_ALWAYS: taken = 1'b1;
            CC_NZ:     taken = !i_state.z;
            CC_Z:      taken = i_state.z;
            CC_C:      taken = i_state.cy;
            CC_NC:     taken = !i_state.cy;
            CC_P:      taken = !i_state.s;
            CC_M:      taken = i_state.s;
            CC_PE:     taken = i_state.p;
            CC_PO:     taken = !i_state.p;
            default:   taken = 1'b0;
        endcase
    end

    always_comb begin
        st        = i_state;
        reg_val   = 8'd0;
        reg_used  = 1'b0;
        sum       = 9'd0;
        diff      = 9'd0;
        logic_val = 8'd0;
        if (!i_item.is_jump) begin
            unique case (i_item.op)
                OP_ADD, OP_ADC: begin
                    sum = {1'b0, i_state.acc} + {1'b0, i_item.operand}
                        + ((i_item.op == OP_ADC) ? {8'd0, i_state.cy} : 9'd0);
                    st.cy  = sum[8];
                    st.acc = sum[7:0];
                end
                OP_SUB, OP_SBB: begin
                    diff = {1'b0, i_state.acc} - {1'b0, i_item.operand}
                         - ((i_item.op == OP_SBB) ? {8'd0, i_state.cy} : 9'd0);
                    st.cy  = diff[8];
                    st.acc = diff[7:0];
                end
                OP_CMP: begin
                    st.cy = i_state.acc < i_item.operand;
                    st.z  = i_state.acc == i_item.operand;
                    st.p  = even_parity(i_state.acc);
                end
                OP_AND, OP_XOR: begin
                    logic_val = (i_item.op == OP_AND) ? (i_state.acc & i_item.operand)
                                                      : (i_state.acc ^ i_item.operand);
                    st.acc = logic_val;
                    st.z   = logic_val == 8'd0;
                    st.s   = logic_val[7];
                    st.p   = even_parity(logic_val);
                    st.cy  = 1'b0;
                    st.ac  = i_item.op == OP_AND;
                end
                OP_INR: begin
                    st.cy    = i_item.operand == 8'hFF;
                    reg_val  = i_item.operand + 8'd1;
                    reg_used = 1'b1;
                end
                OP_DCR: begin
                    st.cy    = i_item.operand == 8'd0;
                    reg_val  = i_item.operand - 8'd1;
                    reg_used = 1'b1;
                end
                OP_STC: begin
                    st.cy = 1'b1;
                end
                default: begin
                    st = i_state;
                end
            endcase
        end
    end

    assign o_state = st;

    always_comb begin
        o_result.acc_out      = st.acc;
        o_result.reg_out      = reg_used ? reg_val : st.acc;
        o_result.cy_out       = st.cy;
        o_result.z_out        = st.z;
        o_result.s_out        = st.s;
        o_result.p_out        = st.p;
        o_result.ac_out       = st.ac;
        o_result.branch_taken = i_item.is_jump && taken;
        if (i_item.is_jump) begin
            o_result.next_pc = taken ? i_item.jump_target : i_item.pc + PC_STEP_JUMP;
        end else begin
            o_result.next_pc = i_item.pc + PC_STEP_ALU;
        end
    end

endmodule

// ===== src/accumulator_alu_with_flags_core.sv =====
// top level: accumulator alu with flags and conditional jump decision
//
// input channel: i_in_valid / o_in_stall with one beat per instruction
// (op, is_jump, operand, cond, pc, jump_target); a beat is taken at a rising
// edge with valid high and stall low.
// output channel: o_out_valid / i_out_stall with one result beat per input
// beat, in order (accumulator, register value, five flags, next pc, taken).
// an instruction passes the input register, then the alu and jump logic
// updates accumulator and flags while loading the result register.
// one beat is taken per cycle unless the receiver stalls; the 8-bit accumulator
// and flag feedback runs through the alu around the state registers.
// a receiver stall holds the result register; the input register still takes
// one more beat, after that o_in_stall follows the output stall.
// synchronous active-low reset empties both registers and clears the
// accumulator and all flags.
module accumulator_alu_with_flags_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_op,
    input  logic        i_is_jump,
    input  logic [7:0]  i_operand,
    input  logic [3:0]  i_cond,
    input  logic [15:0] i_pc,
    input  logic [15:0] i_jump_target,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_reg_out,
    output logic        o_cy_out,
    output logic        o_z_out,
    output logic        o_s_out,
    output logic        o_p_out,
    output logic        o_ac_out,
    output logic [15:0] o_next_pc,
    output logic        o_branch_taken
);
    import aaf_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    logic    advance;
    logic    in_accept;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    aaf_exec u_exec (
        .i_item   (r_in),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.op          <= i_op;
            r_in.is_jump     <= i_is_jump;
            r_in.operand     <= i_operand;
            r_in.cond        <= i_cond;
            r_in.pc          <= i_pc;
            r_in.jump_target <= i_jump_target;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_acc_out      = r_out.acc_out;
    assign o_reg_out      = r_out.reg_out;
    assign o_cy_out       = r_out.cy_out;
    assign o_z_out        = r_out.z_out;
    assign o_s_out        = r_out.s_out;
    assign o_p_out        = r_out.p_out;
    assign o_ac_out       = r_out.ac_out;
    assign o_next_pc      = r_out.next_pc;
    assign o_branch_taken = r_out.branch_taken;

endmodule

// ===== src/aaf_checker.sv =====
// port-level checker for the accumulator alu core, with its bind
`include "assert_macros.svh"

module aaf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_acc_out,
    input logic        o_cy_out,
    input logic [15:0] o_next_pc
);

    // result beat held while stalled
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_acc_out) && $stable(o_cy_out) && $stable(o_next_pc))

    // input stall only when the result side is blocked
    `ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

    // an accepted beat reaches the output when the receiver does not stall it
    `ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && !o_in_stall) ##1 !i_out_stall, o_out_valid)

    // nothing pending right after reset
    `ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_out_valid && !o_in_stall)

endmodule

bind accumulator_alu_with_flags_core aaf_checker u_aaf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_acc_out   (o_acc_out),
    .o_cy_out    (o_cy_out),
    .o_next_pc   (o_next_pc)
);

// ===== bench/testbench.sv =====
// testbench for the accumulator alu core: instruction tracker, beat drivers and result checks
`timescale 1ns / 100ps

import aaf_pkg::*;

class alu_tracker;
    logic [7:0] acc;
    logic       cy, z, s, p, ac;
    t_result    due_results[$];
    int         instrs, jumps, taken_jumps, results, mismatches;

    function new();
        acc = 8'd0;
        {cy, z, s, p, ac} = 5'b0;
        instrs = 0;
        jumps = 0;
        taken_jumps = 0;
        results = 0;
        mismatches = 0;
    endfunction

    function logic cond_holds(logic [3:0] c);
        case (c)
            CC_ALWAYS: return 1'b1;
            CC_NZ:     return !z;
            CC_Z:      return z;
            CC_C:      return cy;
            CC_NC:     return !cy;
            CC_P:      return !s;
            CC_M:      return s;
            CC_PE:     return p;
            CC_PO:     return !p;
            default:   return 1'b0;
        endcase
    endfunction

    function void set_logic_flags();
        z = (acc == 8'd0);
        s = acc[7];
        p = ~^acc;
        cy = 1'b0;
    endfunction

    function void note_instr(t_item it);
        t_result     r;
        logic [8:0]  wide;
        logic [7:0]  reg_val;
        logic        reg_used;
        logic        taken;
        logic [15:0] nxt_pc;
        instrs++;
        reg_used = 1'b0;
        taken = 1'b0;
        reg_val = 8'd0;
        if (it.is_jump) begin
            jumps++;
            if (cond_holds(it.cond)) begin
                nxt_pc = it.jump_target;
                taken = 1'b1;
                taken_jumps++;
            end else begin
                nxt_pc = it.pc + PC_STEP_JUMP;
            end
        end else begin
            nxt_pc = it.pc + PC_STEP_ALU;
            case (it.op)
                OP_ADD: begin
                    wide = {1'b0, acc} + {1'b0, it.operand};
                    cy = wide[8];
                    acc = wide[7:0];
                end
                OP_ADC: begin
                    wide = {1'b0, acc} + {1'b0, it.operand} + {8'd0, cy};
                    cy = wide[8];
                    acc = wide[7:0];
                end
                OP_SUB: begin
                    cy = (it.operand > acc);
                    acc = acc - it.operand;
                end
                OP_SBB: begin
                    wide = {1'b0, it.operand} + {8'd0, cy};
                    cy = ({1'b0, acc} < wide);
                    acc = acc - wide[7:0];
                end
                OP_CMP: begin
                    cy = (acc < it.operand);
                    z = (acc == it.operand);
                    p = ~^acc;
                end
                OP_AND: begin
                    acc = acc & it.operand;
                    set_logic_flags();
                    ac = 1'b1;
                end
                OP_XOR: begin
                    acc = acc ^ it.operand;
                    set_logic_flags();
                    ac = 1'b0;
                end
                OP_INR: begin
                    cy = (it.operand == 8'hFF);
                    reg_val = it.operand + 8'd1;
                    reg_used = 1'b1;
                end
                OP_DCR: begin
                    cy = (it.operand == 8'h00);
                    reg_val = it.operand - 8'd1;
                    reg_used = 1'b1;
                end
                OP_STC: cy = 1'b1;
                default: ;
            endcase
        end
        r.acc_out = acc;
        r.reg_out = reg_used ? reg_val : acc;
        r.cy_out = cy;
        r.z_out = z;
        r.s_out = s;
        r.p_out = p;
        r.ac_out = ac;
        r.next_pc = nxt_pc;
        r.branch_taken = taken;
        due_results.push_back(r);
    endfunction

    task report_mismatch(string what);
        mismatches++;
        $display("mismatch on result %0d: %s", results, what);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(t_result got);
        t_result want;
        results++;
        if (due_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
            return;
        end
        want = due_results.pop_front();
        compare_field("acc_out", 16'(got.acc_out), 16'(want.acc_out));
        compare_field("reg_out", 16'(got.reg_out), 16'(want.reg_out));
        compare_field("cy_out", 16'(got.cy_out), 16'(want.cy_out));
        compare_field("z_out", 16'(got.z_out), 16'(want.z_out));
        compare_field("s_out", 16'(got.s_out), 16'(want.s_out));
        compare_field("p_out", 16'(got.p_out), 16'(want.p_out));
        compare_field("ac_out", 16'(got.ac_out), 16'(want.ac_out));
        compare_field("next_pc", got.next_pc, want.next_pc);
        compare_field("branch_taken", 16'(got.branch_taken), 16'(want.branch_taken));
    endtask
endclass

module testbench;
    import aaf_pkg::*;

    localparam logic [3:0] OP_UNUSED   = 4'd15;
    localparam logic [3:0] CC_UNUSED   = 4'd15;
    localparam int         RANDOM_INSTRS = 1700;
    localparam int         IDLE_LIMIT  = 1000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [3:0]  i_op;
    logic        i_is_jump;
    logic [7:0]  i_operand;
    logic [3:0]  i_cond;
    logic [15:0] i_pc;
    logic [15:0] i_jump_target;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_acc_out;
    logic [7:0]  o_reg_out;
    logic        o_cy_out;
    logic        o_z_out;
    logic        o_s_out;
    logic        o_p_out;
    logic        o_ac_out;
    logic [15:0] o_next_pc;
    logic        o_branch_taken;

    alu_tracker books = new();
    int         idle_cycles = 0;

    accumulator_alu_with_flags_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_is_jump      (i_is_jump),
        .i_operand      (i_operand),
        .i_cond         (i_cond),
        .i_pc           (i_pc),
        .i_jump_target  (i_jump_target),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_acc_out      (o_acc_out),
        .o_reg_out      (o_reg_out),
        .o_cy_out       (o_cy_out),
        .o_z_out        (o_z_out),
        .o_s_out        (o_s_out),
        .o_p_out        (o_p_out),
        .o_ac_out       (o_ac_out),
        .o_next_pc      (o_next_pc),
        .o_branch_taken (o_branch_taken)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_item build_instr(logic jump, logic [3:0] op, logic [7:0] opd,
                                          logic [3:0] cc, logic [15:0] pc, logic [15:0] tgt);
        t_item it;
        it.is_jump = jump;
        it.op = op;
        it.operand = opd;
        it.cond = cc;
        it.pc = pc;
        it.jump_target = tgt;
        return it;
    endfunction

    function automatic t_item rand_instr();
        t_item it;
        it.is_jump = ($urandom_range(99) < 25);
        it.op = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
        it.cond = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        case ($urandom_range(7))
            0: it.operand = 8'h00;
            1: it.operand = 8'hFF;
            2: it.operand = $urandom_range(1) ? 8'h7F : 8'h80;
            3: it.operand = books.acc;
            default: it.operand = 8'($urandom_range(255));
        endcase
        it.pc = ($urandom_range(9) == 0) ? 16'hFFFF - 16'($urandom_range(2))
                                         : 16'($urandom_range(16'hFFFF));
        it.jump_target = 16'($urandom_range(16'hFFFF));
        return it;
    endfunction

    // one input beat, with random gaps unless calm
    task automatic send_beat(input t_item it, input bit calm);
        while (!calm && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= it.op;
        i_is_jump <= it.is_jump;
        i_operand <= it.operand;
        i_cond <= it.cond;
        i_pc <= it.pc;
        i_jump_target <= it.jump_target;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                books.check_result('{acc_out: o_acc_out, reg_out: o_reg_out,
                    cy_out: o_cy_out, z_out: o_z_out, s_out: o_s_out, p_out: o_p_out,
                    ac_out: o_ac_out, next_pc: o_next_pc, branch_taken: o_branch_taken});
            if (i_in_valid && !o_in_stall)
                books.note_instr('{op: i_op, is_jump: i_is_jump, operand: i_operand,
                    cond: i_cond, pc: i_pc, jump_target: i_jump_target});
        end
    end

    // receiver: random stalls, one long hold so the core backs up, then a calm stretch
    initial begin : receiver
        int rc;
        rc = 0;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (rc >= 300 && rc < 400)
                i_out_stall <= 1'b1;
            else if (rc >= 1000 && rc < 1500)
                i_out_stall <= 1'b0;
            else
                i_out_stall <= ($urandom_range(99) < 20);
            rc++;
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [3:0] cc_list [10];
        cc_list = '{CC_ALWAYS, CC_NZ, CC_Z, CC_C, CC_NC, CC_P, CC_M, CC_PE, CC_PO, CC_UNUSED};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_ADD;
        i_is_jump = 1'b0;
        i_operand = 8'd0;
        i_cond = CC_ALWAYS;
        i_pc = 16'd0;
        i_jump_target = 16'd0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: carries, borrows, wraps, flag corners and every condition
        send_beat(build_instr(1'b0, OP_ADD, 8'hFF, CC_ALWAYS, 16'hFFFF, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_ADD, 8'h01, CC_ALWAYS, 16'h0000, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_CMP, 8'hFF, CC_ALWAYS, 16'h1234, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_ADC, 8'h80, CC_ALWAYS, 16'hFFFF, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_SUB, 8'hFF, CC_ALWAYS, 16'h8000, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_SBB, 8'h7F, CC_ALWAYS, 16'h7FFF, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_CMP, 8'h02, CC_ALWAYS, 16'h0001, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_AND, 8'h0F, CC_ALWAYS, 16'h0002, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_XOR, 8'hFF, CC_ALWAYS, 16'h0003, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_INR, 8'hFF, CC_ALWAYS, 16'hFFFF, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_DCR, 8'h00, CC_ALWAYS, 16'h0004, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_STC, 8'h55, CC_ALWAYS, 16'hFFFF, 16'h0), 1'b0);
        send_beat(build_instr(1'b0, OP_UNUSED, 8'hAA, CC_UNUSED, 16'h0005, 16'hFFFF), 1'b0);
        send_beat(build_instr(1'b0, OP_XOR, 8'hFD, CC_ALWAYS, 16'h0006, 16'h0), 1'b0);
        for (int c = 0; c < 10; c++)
            send_beat(build_instr(1'b1, OP_UNUSED, 8'h00, cc_list[c],
                                  (c % 2) ? 16'hFFFE : 16'hFFFF,
                                  (c % 2) ? 16'hFFFF : 16'h0000), 1'b0);

        for (int n = 0; n < RANDOM_INSTRS; n++)
            send_beat(rand_instr(), n >= 700 && n < 1000);
        i_in_valid <= 1'b0;

        // let the monitor note the last beat before draining
        @(posedge i_clk);
        while (books.due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("covered %0d instructions: %0d jumps, %0d of them taken",
                 books.instrs, books.jumps, books.taken_jumps);
        $display("compared %0d result beats, %0d field mismatches",
                 books.results, books.mismatches);
        if (books.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
